@@ rtl/pht_pkg.sv @@
// Package for the property hash table: types, codes and default sizes.
`timescale 1ns / 1ps
package pht_pkg;

    localparam int PHT_TABLE_SLOTS  = 256;
    localparam int PHT_PROBE_WINDOW = 3;
    // The bucket count stands this many slots below the slot count.
    localparam int PHT_HOME_GAP     = 3;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_INSERTED = 3'd1,
        ST_MISS     = 3'd2,
        ST_FULL     = 3'd3,
        ST_INVALID  = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        CMD_LOOKUP = 1'b0,
        CMD_SET    = 1'b1
    } t_command;

    typedef struct packed {
        t_command    command;
        logic [15:0] key;
        logic [15:0] entry_type;
        logic [63:0] entry_value;
    } t_in_req;

    typedef struct packed {
        t_status     status;
        logic [15:0] found_type;
        logic [63:0] found_value;
    } t_out_res;

    typedef struct packed {
        logic [15:0] key;
        logic [15:0] entry_type;
        logic [63:0] entry_value;
    } t_slot;

    localparam int PHT_SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic    in_ready;
        logic    load;
        logic    mul_en;
        logic    qb_en;
        logic    red_en;
        logic    rd_en;
        logic    step_inc;
        logic    wr_en;
        logic    clr_wr;
        logic    res_set;
        logic    res_take;
        t_status res_code;
        logic    out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic key_zero;
        logic is_set;
        logic key_match;
        logic slot_empty;
        logic last_step;
        logic clear_done;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/pht_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module pht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pht_ctrl.sv @@
// Controller state machine of the property hash table.
`timescale 1ns / 1ps
module pht_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  pht_pkg::t_dp_stat  i_stat,
    output pht_pkg::t_ctrl_cmd o_cmd
);
    import pht_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_QB    = 8'b0000_1000,
        S_RED   = 8'b0001_0000,
        S_RD    = 8'b0010_0000,
        S_CMP   = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } t_state;

    t_state    r_state;
    t_state    n_state;
    t_ctrl_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        w_cmd.res_code = ST_MISS;
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.clr_wr = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                w_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                if (i_stat.key_zero) begin
                    w_cmd.res_set  = 1'b1;
                    w_cmd.res_code = ST_INVALID;
                    n_state        = S_RESP;
                end else begin
                    w_cmd.mul_en = 1'b1;
                    n_state      = S_QB;
                end
            end
            S_QB: begin
                w_cmd.qb_en = 1'b1;
                n_state     = S_RED;
            end
            S_RED: begin
                w_cmd.red_en = 1'b1;
                n_state      = S_RD;
            end
            S_RD: begin
                w_cmd.rd_en = 1'b1;
                n_state     = S_CMP;
            end
            S_CMP: begin
                if (i_stat.key_match) begin
                    w_cmd.res_set  = 1'b1;
                    w_cmd.res_code = ST_HIT;
                    w_cmd.res_take = !i_stat.is_set;
                    w_cmd.wr_en    = i_stat.is_set;
                    n_state        = S_RESP;
                end else if (i_stat.is_set && i_stat.slot_empty) begin
                    w_cmd.res_set  = 1'b1;
                    w_cmd.res_code = ST_INSERTED;
                    w_cmd.wr_en    = 1'b1;
                    n_state        = S_RESP;
                end else if (i_stat.last_step) begin
                    w_cmd.res_set  = 1'b1;
                    w_cmd.res_code = i_stat.is_set ? ST_FULL : ST_MISS;
                    n_state        = S_RESP;
                end else begin
                    w_cmd.step_inc = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = w_cmd;

    // A slot is only written straight after its read has come back.
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_en |-> $past(r_state == S_RD))
        else $error("slot write without a preceding read");

    a_wr_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_en |-> i_stat.is_set && (i_stat.key_match || i_stat.slot_empty))
        else $error("slot write on a lookup or an occupied foreign slot");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> i_stat.out_free)
        else $error("result register overwritten while still waiting");

    a_load_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> (r_state == S_MUL))
        else $error("accepted request did not start hashing");

endmodule

@@ rtl/pht_datapath.sv @@
// Datapath of the property hash table: request registers, home slot modulo, probe and slot RAM.
`timescale 1ns / 1ps
module pht_datapath #(
    parameter int TABLE_SLOTS  = pht_pkg::PHT_TABLE_SLOTS,
    parameter int PROBE_WINDOW = pht_pkg::PHT_PROBE_WINDOW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pht_pkg::t_ctrl_cmd i_cmd,
    input  pht_pkg::t_in_req   i_in_req,
    input  logic               i_out_ready,
    output pht_pkg::t_dp_stat  o_stat,
    output logic               o_out_valid,
    output pht_pkg::t_out_res  o_out_res
);
    import pht_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_SLOTS);
    localparam int STEP_W  = (PROBE_WINDOW > 1) ? $clog2(PROBE_WINDOW) : 1;
    localparam int BUCKETS = TABLE_SLOTS - PHT_HOME_GAP;
    // floor(2^32 / BUCKETS): the quotient estimate is low by at most one.
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUCKETS);
    localparam logic [15:0] BKT16 = 16'(BUCKETS);
    localparam logic [16:0] BKT17 = 17'(BUCKETS);
    localparam logic [IDX_W:0] SLOTS_X = (IDX_W + 1)'(TABLE_SLOTS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROBE_WINDOW - 1);

    t_in_req            r_req;
    logic [15:0]        r_q;
    logic [31:0]        r_qb;
    logic [IDX_W-1:0]   r_home;
    logic [STEP_W-1:0]  r_step;
    logic [IDX_W-1:0]   r_addr;
    logic [IDX_W-1:0]   r_clr_idx;
    t_out_res           r_pend;
    t_out_res           r_out;
    logic               r_out_valid;

    logic [47:0]        w_prod;
    logic [16:0]        w_rem;
    logic [16:0]        w_home;
    logic [IDX_W:0]     w_sum;
    logic [IDX_W-1:0]   w_probe;
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    t_slot              w_wdata;
    logic [PHT_SLOT_W-1:0] w_rdata;
    t_slot              w_slot;

    // Home slot = key mod BUCKETS by reciprocal multiply and one correction.
    assign w_prod = {32'd0, r_req.key} * {16'd0, RECIP};
    assign w_rem  = {1'b0, r_req.key} - r_qb[16:0];
    assign w_home = (w_rem >= BKT17) ? (w_rem - BKT17) : w_rem;

    assign w_sum   = (IDX_W + 1)'(r_home) + (IDX_W + 1)'(r_step);
    assign w_probe = (w_sum >= SLOTS_X) ? IDX_W'(w_sum - SLOTS_X) : w_sum[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_req;
        end
        if (i_cmd.mul_en) begin
            r_q <= w_prod[47:32];
        end
        if (i_cmd.qb_en) begin
            r_qb <= {16'd0, r_q} * {16'd0, BKT16};
        end
        if (i_cmd.red_en) begin
            r_home <= w_home[IDX_W-1:0];
            r_step <= '0;
        end else if (i_cmd.step_inc) begin
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.rd_en) begin
            r_addr <= w_probe;
        end
        if (i_cmd.res_set) begin
            r_pend.status      <= i_cmd.res_code;
            r_pend.found_type  <= i_cmd.res_take ? w_slot.entry_type : 16'd0;
            r_pend.found_value <= i_cmd.res_take ? w_slot.entry_value : 64'd0;
        end
        if (i_cmd.out_load) begin
            r_out <= r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_we    = i_cmd.clr_wr | i_cmd.wr_en;
    assign w_waddr = i_cmd.clr_wr ? r_clr_idx : r_addr;
    always_comb begin
        if (i_cmd.clr_wr) begin
            w_wdata = '0;
        end else begin
            w_wdata.key         = r_req.key;
            w_wdata.entry_type  = r_req.entry_type;
            w_wdata.entry_value = r_req.entry_value;
        end
    end

    pht_ram #(
        .WIDTH (PHT_SLOT_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_probe),
        .o_rdata (w_rdata)
    );

    assign w_slot = t_slot'(w_rdata);

    assign o_stat.key_zero   = (r_req.key == 16'd0);
    assign o_stat.is_set     = (r_req.command == CMD_SET);
    assign o_stat.key_match  = (w_slot.key == r_req.key);
    assign o_stat.slot_empty = (w_slot.key == 16'd0);
    assign o_stat.last_step  = (r_step == LAST_STEP);
    assign o_stat.clear_done = (r_clr_idx == IDX_W'(TABLE_SLOTS - 1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

@@ rtl/property_hash_table.sv @@
// Top level of the property hash table: controller and datapath.
`timescale 1ns / 1ps
// Open-addressing key/value table with linear probing over TABLE_SLOTS slots of
// 16-bit key, 16-bit type and 64-bit value, held in one synchronous RAM. A
// request either looks up a key or sets it; the home slot is the key modulo
// TABLE_SLOTS - 3 and up to PROBE_WINDOW consecutive slots are probed, wrapping
// past the last slot. After reset the block clears the key store, one slot a
// cycle, with o_in_ready low. A request then passes from acceptance through
// the modulo by reciprocal multiply (multiply, quotient times bucket count and
// reduce states), then per probed slot a registered RAM read and a compare (a
// write-back shares the compare cycle), up to PROBE_WINDOW probes, and then
// the load of its result into the output register, which waits until that
// register is free. A request with key zero goes straight to the result. One
// request is worked on at a time; the next is accepted while the previous
// result still waits to be taken.
module property_hash_table #(
    parameter int TABLE_SLOTS  = pht_pkg::PHT_TABLE_SLOTS,
    parameter int PROBE_WINDOW = pht_pkg::PHT_PROBE_WINDOW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pht_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pht_pkg::t_out_res o_out_res
);
    import pht_pkg::*;

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    pht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pht_datapath #(
        .TABLE_SLOTS  (TABLE_SLOTS),
        .PROBE_WINDOW (PROBE_WINDOW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_req    (i_in_req),
        .i_out_ready (i_out_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

    assign o_in_ready = w_cmd.in_ready;

endmodule

@@ dv/tb_property_hash_table.sv @@
// Self-checking testbench for the property hash table with a predictor of its own.
`timescale 1ns / 1ps
module tb_property_hash_table;
    import pht_pkg::*;

    localparam int BUCKETS       = PHT_TABLE_SLOTS - PHT_HOME_GAP;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 5000;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_ready;
    t_in_req  i_in_req    = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_out_res o_out_res;

    // Shadow copy of the table contents, updated as each request is accepted.
    logic [15:0] shadow_keys   [PHT_TABLE_SLOTS];
    logic [15:0] shadow_types  [PHT_TABLE_SLOTS];
    logic [63:0] shadow_values [PHT_TABLE_SLOTS];

    t_out_res    expected_responses[$];
    t_out_res    next_expected;
    logic [15:0] key_pool[$];
    int unsigned errors       = 0;
    int unsigned idle_cycles  = 0;
    int unsigned burst_left   = 0;
    int unsigned holds_asked  = 0;
    int unsigned holds_done   = 0;
    bit          gaps_on      = 1'b1;

    property_hash_table i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_res predict_response(input t_in_req req);
        t_out_res    res;
        int unsigned home;
        int unsigned slot;
        bit          done;
        res  = '0;
        done = 1'b0;
        if (req.key == 16'h0) begin
            res.status = ST_INVALID;
            return res;
        end
        home = req.key % BUCKETS;
        if (req.command == CMD_SET) begin
            res.status = ST_FULL;
        end else begin
            res.status = ST_MISS;
        end
        for (int i = 0; i < PHT_PROBE_WINDOW; i++) begin
            slot = (home + i) % PHT_TABLE_SLOTS;
            if (!done && shadow_keys[slot] == req.key) begin
                res.status = ST_HIT;
                if (req.command == CMD_SET) begin
                    shadow_types[slot]  = req.entry_type;
                    shadow_values[slot] = req.entry_value;
                end else begin
                    res.found_type  = shadow_types[slot];
                    res.found_value = shadow_values[slot];
                end
                done = 1'b1;
            end else if (!done && req.command == CMD_SET && shadow_keys[slot] == 16'h0) begin
                shadow_keys[slot]   = req.key;
                shadow_types[slot]  = req.entry_type;
                shadow_values[slot] = req.entry_value;
                res.status = ST_INSERTED;
                done = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic t_in_req make_request(input t_command cmd, input logic [15:0] key,
                                             input logic [15:0] etype,
                                             input logic [63:0] evalue);
        t_in_req req;
        req.command     = cmd;
        req.key         = key;
        req.entry_type  = etype;
        req.entry_value = evalue;
        return req;
    endfunction

    // Offers one request in bursts with random gaps and records its expected response.
    task automatic send_request(input t_in_req req);
        int unsigned gap;
        gap = 0;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                if ($urandom_range(0, 3) != 0) begin
                    gap = $urandom_range(1, 8);
                end
            end
            burst_left--;
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_responses.push_back(predict_response(req));
    endtask

    task automatic test_invalid_key();
        send_request(make_request(CMD_LOOKUP, 16'h0, 16'h0, 64'h0));
        send_request(make_request(CMD_SET, 16'h0, 16'hFFFF, '1));
        send_request(make_request(CMD_LOOKUP, 16'h0, 16'hFFFF, '1));
    endtask

    task automatic test_insert_and_update();
        send_request(make_request(CMD_SET, 16'h0001, 16'h0000, 64'h0));
        send_request(make_request(CMD_LOOKUP, 16'h0001, 16'h0000, 64'h0));
        send_request(make_request(CMD_SET, 16'hFFFF, 16'hFFFF, '1));
        send_request(make_request(CMD_LOOKUP, 16'hFFFF, 16'h0000, 64'h0));
        send_request(make_request(CMD_SET, 16'h0001, 16'hA5C3, 64'h0123_4567_89AB_CDEF));
        send_request(make_request(CMD_LOOKUP, 16'h0001, 16'hFFFF, '1));
        send_request(make_request(CMD_LOOKUP, 16'h0002, 16'h0000, 64'h0));
    endtask

    // Four keys sharing the highest home slot: the fourth set finds the window full.
    task automatic test_full_window();
        for (int m = 0; m < 4; m++) begin
            send_request(make_request(CMD_SET, 16'(BUCKETS - 1 + m * BUCKETS),
                                      16'(m + 1), 64'(m) << 60));
        end
        send_request(make_request(CMD_SET, 16'(2 * BUCKETS - 1), 16'h7777, '1));
        send_request(make_request(CMD_LOOKUP, 16'(3 * BUCKETS - 1), 16'h0, 64'h0));
        send_request(make_request(CMD_LOOKUP, 16'(2 * BUCKETS - 1), 16'h0, 64'h0));
        send_request(make_request(CMD_LOOKUP, 16'(4 * BUCKETS - 1), 16'h0, 64'h0));
        send_request(make_request(CMD_LOOKUP, 16'(5 * BUCKETS - 1), 16'h0, 64'h0));
    endtask

    task automatic test_random_traffic(input int unsigned count);
        t_in_req     req;
        int unsigned pick;
        int unsigned home;
        // Groups of keys that collide on one home slot keep hits, updates and full windows common.
        if (key_pool.size() == 0) begin
            for (int g = 0; g < 12; g++) begin
                home = $urandom_range(0, BUCKETS - 1);
                for (int m = 0; m < 5; m++) begin
                    key_pool.push_back(16'(home + BUCKETS * $urandom_range(1, 258)));
                end
            end
        end
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 1) == 1) begin
                req.command = CMD_SET;
            end else begin
                req.command = CMD_LOOKUP;
            end
            if (pick < 4) begin
                req.key = 16'h0;
            end else if (pick < 30) begin
                req.key = 16'($urandom);
            end else begin
                req.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end
            case ($urandom_range(0, 7))
                0: begin
                    req.entry_type  = '0;
                    req.entry_value = '0;
                end
                1: begin
                    req.entry_type  = '1;
                    req.entry_value = '1;
                end
                default: begin
                    req.entry_type  = 16'($urandom);
                    req.entry_value = {$urandom, $urandom};
                end
            endcase
            send_request(req);
        end
    endtask

    // The sink holds off for a long stretch while requests keep coming, so the input stalls.
    task automatic test_output_stall();
        holds_asked++;
        gaps_on = 1'b0;
        test_random_traffic(40);
        gaps_on = 1'b1;
    endtask

    initial begin : result_sink
        int unsigned mode;
        int unsigned mode_left;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_done++;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 1) == 1);
                2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (mode_left % 5 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_responses.size() == 0) begin
                $display("%0t: unexpected response, expected none, got status %0d type %h value %h",
                         $time, o_out_res.status, o_out_res.found_type, o_out_res.found_value);
                errors++;
            end else begin
                next_expected = expected_responses.pop_front();
                if (o_out_res.status !== next_expected.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, next_expected.status, o_out_res.status);
                    errors++;
                end
                if (o_out_res.found_type !== next_expected.found_type) begin
                    $display("%0t: found_type mismatch, expected %h, got %h",
                             $time, next_expected.found_type, o_out_res.found_type);
                    errors++;
                end
                if (o_out_res.found_value !== next_expected.found_value) begin
                    $display("%0t: found_value mismatch, expected %h, got %h",
                             $time, next_expected.found_value, o_out_res.found_value);
                    errors++;
                end
            end
        end
    end

    // Ends the run if neither channel moves a request for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d responses outstanding", $time,
                     expected_responses.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int s = 0; s < PHT_TABLE_SLOTS; s++) begin
            shadow_keys[s]   = 16'h0;
            shadow_types[s]  = 16'h0;
            shadow_values[s] = 64'h0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_invalid_key();
        test_insert_and_update();
        test_full_window();
        test_random_traffic(700);
        test_output_stall();
        test_random_traffic(900);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/pht_pkg.sv
rtl/pht_ram.sv
rtl/pht_ctrl.sv
rtl/pht_datapath.sv
rtl/property_hash_table.sv
dv/tb_property_hash_table.sv
